// ===== src/temporal_reuse_confidence_defines.svh =====
// ----------------------------------------------------------------------------
// Temporal reuse confidence assertion macros
// Concurrent assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef TEMPORAL_REUSE_CONFIDENCE_DEFINES_SVH
`define TEMPORAL_REUSE_CONFIDENCE_DEFINES_SVH

// assertion on an explicit clock and active-low reset
`define TRC_ASSERT_CLK(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// assertion on clk / rst_n of the enclosing scope
`define TRC_ASSERT(lbl, prop, msg) \
  `TRC_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

// ===== src/trc_pkg.sv =====
// ----------------------------------------------------------------------------
// Temporal reuse confidence package
// Shared constants, types and helpers for the confidence pipeline.
// ----------------------------------------------------------------------------
package trc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int Q_W        = FRAC_BITS + 1;        // Q1.16 incl. 1.0
  localparam int GUIDE_W    = 18;
  localparam int MAG_W      = 20;
  localparam int MPOS_W     = MAG_W - 1;
  localparam int SCL_W      = 12;
  localparam int SCLS_W     = SCL_W + 8;            // scale in 8-fraction pixels
  localparam int DEN_W      = SCLS_W + 1;
  localparam int NUM_W      = SCLS_W + FRAC_BITS;
  localparam int PROD_W     = 3 * Q_W + 1;          // cube compare width
  localparam int ITER_N     = Q_W;                  // one result bit per stage
  localparam int CFG_IDX_W  = 3;
  localparam int PIPE_LAT   = 23;

  localparam logic [Q_W-1:0] ONE = Q_W'(1) << FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONF_THR  = 3'd0,
    CFG_DISOC_THR = 3'd1,
    CFG_VEL_SCALE = 3'd2,
    CFG_VEL_FLOOR = 3'd3
  } cfg_idx_t;

  // sideband that rides beside the arithmetic
  typedef struct packed {
    logic           valid;
    logic           cut;
    logic           forced;
    logic [Q_W-1:0] dis;
    logic [Q_W-1:0] fl;
  } sb_t;

  function automatic logic [Q_W-1:0] clamp_unit(input logic signed [GUIDE_W-1:0] g);
    logic [Q_W-1:0] res;
    if (g < 0) begin
      res = '0;
    end else if (g > $signed({1'b0, ONE})) begin
      res = ONE;
    end else begin
      res = g[Q_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== src/trc_cbrt.sv =====
// ----------------------------------------------------------------------------
// Cube root pipeline
// Floor cube root, one result bit per stage, square and cube kept incrementally.
// ----------------------------------------------------------------------------
module trc_cbrt (
  input  logic                        clk,
  input  logic [trc_pkg::PROD_W-1:0]  p_i,
  output logic [trc_pkg::Q_W-1:0]     root_o
);
  import trc_pkg::*;

  logic [Q_W-1:0]      rt_r [0:ITER_N-1];
  logic [2*Q_W-1:0]    sq_r [0:ITER_N-1];
  logic [PROD_W-1:0]   cb_r [0:ITER_N-1];
  logic [PROD_W-1:0]   pp_r [0:ITER_N-1];

  for (genvar k = 0; k < ITER_N; k++) begin : g_stage
    localparam int B = ITER_N - 1 - k;
    logic [Q_W-1:0]    r_cur;
    logic [2*Q_W-1:0]  s_cur;
    logic [PROD_W-1:0] c_cur, p_cur, r_w, s_w, c3, c2w;

    if (k == 0) begin : g_first
      assign r_cur = '0;
      assign s_cur = '0;
      assign c_cur = '0;
      assign p_cur = p_i;
    end else begin : g_next
      assign r_cur = rt_r[k-1];
      assign s_cur = sq_r[k-1];
      assign c_cur = cb_r[k-1];
      assign p_cur = pp_r[k-1];
    end

    assign r_w = PROD_W'(r_cur);
    assign s_w = PROD_W'(s_cur);
    // (r + 2^B)^3 and (r + 2^B)^2 from the running terms
    assign c3  = c_cur + ((s_w + (s_w << 1)) << B) + ((r_w + (r_w << 1)) << (2 * B))
               + (PROD_W'(1) << (3 * B));
    assign c2w = s_w + (r_w << (B + 1)) + (PROD_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      pp_r[k] <= p_cur;
      if (c3 <= p_cur) begin
        rt_r[k] <= r_cur | (Q_W'(1) << B);
        sq_r[k] <= c2w[2*Q_W-1:0];
        cb_r[k] <= c3;
      end else begin
        rt_r[k] <= r_cur;
        sq_r[k] <= s_cur;
        cb_r[k] <= c_cur;
      end
    end
  end

  assign root_o = rt_r[ITER_N-1];

endmodule

// ===== src/trc_div.sv =====
// ----------------------------------------------------------------------------
// Restoring divider pipeline
// Velocity penalty quotient, one quotient bit per stage.
// ----------------------------------------------------------------------------
module trc_div (
  input  logic                       clk,
  input  logic [trc_pkg::NUM_W-1:0]  num_i,
  input  logic [trc_pkg::DEN_W-1:0]  den_i,
  output logic [trc_pkg::Q_W-1:0]    q_o
);
  import trc_pkg::*;

  localparam int CMP_W = NUM_W + 2;

  logic [NUM_W-1:0] rem_r [0:ITER_N-1];
  logic [DEN_W-1:0] den_r [0:ITER_N-1];
  logic [Q_W-1:0]   quo_r [0:ITER_N-1];

  for (genvar k = 0; k < ITER_N; k++) begin : g_stage
    localparam int B = ITER_N - 1 - k;
    logic [NUM_W-1:0] rem_cur;
    logic [DEN_W-1:0] den_cur;
    logic [Q_W-1:0]   quo_cur;
    logic [CMP_W-1:0] dsh, rem_w, diff;

    if (k == 0) begin : g_first
      assign rem_cur = num_i;
      assign den_cur = den_i;
      assign quo_cur = '0;
    end else begin : g_next
      assign rem_cur = rem_r[k-1];
      assign den_cur = den_r[k-1];
      assign quo_cur = quo_r[k-1];
    end

    assign dsh   = CMP_W'(den_cur) << B;
    assign rem_w = CMP_W'(rem_cur);
    assign diff  = rem_w - dsh;

    always_ff @(posedge clk) begin
      den_r[k] <= den_cur;
      if (rem_w >= dsh) begin
        rem_r[k] <= diff[NUM_W-1:0];
        quo_r[k] <= quo_cur | (Q_W'(1) << B);
      end else begin
        rem_r[k] <= rem_cur;
        quo_r[k] <= quo_cur;
      end
    end
  end

  assign q_o = quo_r[ITER_N-1];

endmodule

// ===== src/temporal_reuse_confidence.sv =====
// ----------------------------------------------------------------------------
// Temporal reuse confidence
// Per-pixel history reuse confidence with reject and reset flags.
// ----------------------------------------------------------------------------
// Path: stage 1, stages 2 and 3, cube root pipeline, then stages A, B and C to out_valid.
// Throughput: one item per cycle; busy stays low, the 17-stage cube root and
// divider pipelines take a new operand every cycle.
// Reset: synchronous active-low rst_n clears the valid pipe and loads the
// register defaults.
module temporal_reuse_confidence (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_camera_cut,
  input  logic                          in_has_depth,
  input  logic                          in_not_finite,
  input  logic signed [17:0]            in_motion_confidence,
  input  logic signed [17:0]            in_fb_agreement,
  input  logic signed [17:0]            in_depth_agreement,
  input  logic signed [17:0]            in_disocclusion_ratio,
  input  logic signed [19:0]            in_motion_magnitude,
  output logic                          out_valid,
  output logic [16:0]                   out_confidence,
  output logic                          out_reject_history,
  output logic                          out_reset_history,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [trc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [16:0]                   cfg_data
);
  import trc_pkg::*;

  localparam int SB_N = ITER_N + 3;

  logic [Q_W-1:0]   conf_thr_r, disoc_thr_r, vel_floor_r;
  logic [SCL_W-1:0] vel_scale_r;

  logic             accept;
  logic [SCL_W-1:0] scl;
  logic [MPOS_W-1:0] mpos;
  logic [Q_W-1:0]   fl_sat;
  sb_t              sb_in;

  logic [Q_W-1:0]   mc1_r, fb1_r, dp1_r, dp2_r;
  logic [NUM_W-1:0] num1_r, num2_r, num3_r;
  logic [DEN_W-1:0] den1_r, den2_r, den3_r;
  logic [2*Q_W-1:0] p2_r;
  logic [PROD_W-1:0] p3_r;
  sb_t              sb_r [0:SB_N-1];

  logic [Q_W-1:0]   root, pen, guide;
  logic [2*Q_W-1:0] vp, tp, cp;
  logic [Q_W-1:0]   vf_a_r, t_a_r, conf_b_r;
  logic [Q_W:0]     vf_sum, conf_sh;
  sb_t              sb_a_r, sb_b_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conf_thr_r  <= Q_W'(22938);
      disoc_thr_r <= Q_W'(36045);
      vel_scale_r <= SCL_W'(192);
      vel_floor_r <= Q_W'(49152);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CONF_THR:  conf_thr_r  <= cfg_data;
        CFG_DISOC_THR: disoc_thr_r <= cfg_data;
        CFG_VEL_SCALE: vel_scale_r <= cfg_data[SCL_W-1:0];
        CFG_VEL_FLOOR: vel_floor_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: clamp guides, build the divider operands
  assign scl    = (vel_scale_r == '0) ? SCL_W'(1) : vel_scale_r;
  assign mpos   = (in_motion_magnitude > 0) ? in_motion_magnitude[MPOS_W-1:0] : '0;
  assign fl_sat = (vel_floor_r > ONE) ? ONE : vel_floor_r;

  assign sb_in.valid  = accept;
  assign sb_in.cut    = in_camera_cut;
  assign sb_in.forced = in_camera_cut || !in_has_depth || in_not_finite;
  assign sb_in.dis    = clamp_unit(in_disocclusion_ratio);
  assign sb_in.fl     = fl_sat;

  always_ff @(posedge clk) begin
    mc1_r  <= clamp_unit(in_motion_confidence);
    fb1_r  <= clamp_unit(in_fb_agreement);
    dp1_r  <= clamp_unit(in_depth_agreement);
    num1_r <= {scl, 8'd0, FRAC_BITS'(0)};
    den1_r <= DEN_W'({scl, 8'd0}) + DEN_W'(mpos);
    // stage 2 and 3: triple product
    p2_r   <= mc1_r * fb1_r;
    dp2_r  <= dp1_r;
    num2_r <= num1_r;
    den2_r <= den1_r;
    p3_r   <= PROD_W'(p2_r) * PROD_W'(dp2_r);
    num3_r <= num2_r;
    den3_r <= den2_r;
  end

  // sideband pipe: valid bits under reset, payload free running
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SB_N; i++) sb_r[i].valid <= 1'b0;
      sb_a_r.valid <= 1'b0;
      sb_b_r.valid <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      sb_r[0].valid <= sb_in.valid;
      for (int i = 1; i < SB_N; i++) sb_r[i].valid <= sb_r[i-1].valid;
      sb_a_r.valid <= sb_r[SB_N-1].valid;
      sb_b_r.valid <= sb_a_r.valid;
      out_valid    <= sb_b_r.valid;
    end
    sb_r[0].cut    <= sb_in.cut;
    sb_r[0].forced <= sb_in.forced;
    sb_r[0].dis    <= sb_in.dis;
    sb_r[0].fl     <= sb_in.fl;
    for (int i = 1; i < SB_N; i++) begin
      sb_r[i].cut    <= sb_r[i-1].cut;
      sb_r[i].forced <= sb_r[i-1].forced;
      sb_r[i].dis    <= sb_r[i-1].dis;
      sb_r[i].fl     <= sb_r[i-1].fl;
    end
    sb_a_r.cut    <= sb_r[SB_N-1].cut;
    sb_a_r.forced <= sb_r[SB_N-1].forced;
    sb_a_r.dis    <= sb_r[SB_N-1].dis;
    sb_a_r.fl     <= sb_r[SB_N-1].fl;
    sb_b_r.cut    <= sb_a_r.cut;
    sb_b_r.forced <= sb_a_r.forced;
    sb_b_r.dis    <= sb_a_r.dis;
    sb_b_r.fl     <= sb_a_r.fl;
  end

  trc_cbrt u_cbrt (
    .clk    (clk),
    .p_i    (p3_r),
    .root_o (root)
  );

  trc_div u_div (
    .clk   (clk),
    .num_i (num3_r),
    .den_i (den3_r),
    .q_o   (pen)
  );

  // stage A: velocity weight and disocclusion scaling
  assign guide  = (root > ONE) ? ONE : root;
  assign vp     = (ONE - sb_r[SB_N-1].fl) * pen;
  assign tp     = guide * (ONE - sb_r[SB_N-1].dis);
  assign vf_sum = (Q_W+1)'(sb_r[SB_N-1].fl) + (Q_W+1)'(vp >> FRAC_BITS);

  always_ff @(posedge clk) begin
    vf_a_r <= vf_sum[Q_W-1:0];
    t_a_r  <= tp[FRAC_BITS+Q_W-1:FRAC_BITS];
  end

  // stage B: final product, saturate at one
  assign cp      = t_a_r * vf_a_r;
  assign conf_sh = (Q_W+1)'(cp >> FRAC_BITS);

  always_ff @(posedge clk) begin
    conf_b_r <= (conf_sh > (Q_W+1)'(ONE)) ? ONE : conf_sh[Q_W-1:0];
  end

  // stage C: thresholds and forced results
  always_ff @(posedge clk) begin
    if (sb_b_r.forced) begin
      out_confidence     <= '0;
      out_reject_history <= 1'b1;
      out_reset_history  <= sb_b_r.cut;
    end else begin
      out_confidence     <= conf_b_r;
      out_reject_history <= (conf_b_r < conf_thr_r) || (sb_b_r.dis >= disoc_thr_r);
      out_reset_history  <= 1'b0;
    end
  end

endmodule

// ===== src/trc_checker.sv =====
// ----------------------------------------------------------------------------
// Temporal reuse confidence checker
// Port-level timing and flag consistency checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "temporal_reuse_confidence_defines.svh"

module trc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_camera_cut,
  input logic        out_valid,
  input logic [16:0] out_confidence,
  input logic        out_reject_history,
  input logic        out_reset_history
);
  import trc_pkg::*;

  `TRC_ASSERT(a_out_from_start, out_valid |-> $past(start && !busy, PIPE_LAT), "result without transfer")
  `TRC_ASSERT(a_reset_forced, (out_valid && out_reset_history) |-> (out_reject_history && out_confidence == 17'd0), "reset without forced result")
  `TRC_ASSERT(a_conf_range, out_valid |-> (out_confidence <= ONE), "confidence above one")
  `TRC_ASSERT(a_reset_cut, (out_valid && out_reset_history) |-> $past(in_camera_cut, PIPE_LAT), "reset without cut")

endmodule

bind temporal_reuse_confidence trc_checker u_trc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .in_camera_cut      (in_camera_cut),
  .out_valid          (out_valid),
  .out_confidence     (out_confidence),
  .out_reject_history (out_reject_history),
  .out_reset_history  (out_reset_history)
);
